// File: src/mbdid_pkg.sv
// ----------------------------------------------------------------------------
// Modbus device identification response parser package
// Shared constants, codes and the per-byte result bundle type.
// ----------------------------------------------------------------------------
package mbdid_pkg;

    localparam int OUT_COUNT_BITS = 16;

    localparam logic [3:0] HDR_DONE      = 4'd14;
    localparam logic [3:0] HDR_PROTO_HI  = 4'd2;
    localparam logic [3:0] HDR_PROTO_LO  = 4'd3;
    localparam logic [3:0] HDR_FUNC      = 4'd7;
    localparam logic [3:0] HDR_OBJ_COUNT = 4'd13;

    localparam logic [7:0] FUNC_CODE = 8'd43;
    localparam logic [7:0] NEWLINE   = 8'd10;

    localparam logic [15:0] CAP_RESET = 16'd2048;

    localparam logic [1:0] PH_ID    = 2'd0;
    localparam logic [1:0] PH_LEN   = 2'd1;
    localparam logic [1:0] PH_VALUE = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_PROTO = 2'd1;
    localparam logic [1:0] ST_BAD_FUNC  = 2'd2;
    localparam logic [1:0] ST_TRUNC     = 2'd3;

    typedef struct packed {
        logic       char_v;
        logic [7:0] char_byte;
        logic       nl_v;
        logic       st_v;
        logic [1:0] status;
    } t_bundle;

endpackage

// File: src/mbdid_if.sv
// ----------------------------------------------------------------------------
// Modbus device identification parser channels
// Valid/ready channels for received bytes, results and the capacity write.
// ----------------------------------------------------------------------------
interface mbdid_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       frame_last;

    modport source (output valid, output rx_byte, output frame_last, input ready);
    modport sink (input valid, input rx_byte, input frame_last, output ready);
endinterface

interface mbdid_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       is_status;
    logic [1:0] status;
    logic       last;

    modport source (output valid, output out_byte, output is_status, output status,
                    output last, input ready);
    modport sink (input valid, input out_byte, input is_status, input status,
                  input last, output ready);
endinterface

interface mbdid_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] out_capacity;

    modport source (output valid, output out_capacity, input ready);
    modport sink (input valid, input out_capacity, output ready);
endinterface

// File: src/mbdid_parser.sv
// ----------------------------------------------------------------------------
// Frame parser
// Tracks header and object state and forms the result bundle of each beat.
// ----------------------------------------------------------------------------
module mbdid_parser (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  logic [7:0]         i_rx_byte,
    input  logic               i_frame_last,
    input  logic               i_cfg_we,
    input  logic [15:0]        i_cfg_data,
    output logic               o_push,
    output mbdid_pkg::t_bundle o_bundle
);

    localparam int CntW = mbdid_pkg::OUT_COUNT_BITS;
    localparam int CapW = (CntW > 16) ? CntW : 16;
    localparam int SumW = CapW + 2;

    logic [15:0]     r_capacity;
    logic [3:0]      r_hdr_pos, n_hdr_pos;
    logic [1:0]      r_err, n_err;
    logic [7:0]      r_objs, n_objs;
    logic [1:0]      r_phase, n_phase;
    logic [7:0]      r_val_left, n_val_left;
    logic [CntW-1:0] r_used, n_used;
    logic            r_emit, n_emit;

    logic [CapW-1:0] cap_wide;
    logic [CapW-1:0] mask_wide;
    logic [CapW-1:0] cap_eff;
    logic [SumW-1:0] need;
    logic            fits;
    logic            end_obj;
    mbdid_pkg::t_bundle bundle;

    assign cap_wide  = CapW'(r_capacity);
    assign mask_wide = CapW'({CntW{1'b1}});
    assign cap_eff   = (cap_wide > mask_wide) ? mask_wide : cap_wide;
    assign need      = SumW'(r_used) + SumW'(i_rx_byte) + SumW'(1);
    assign fits      = (need <= SumW'(cap_eff));

    always_comb begin
        n_hdr_pos  = r_hdr_pos;
        n_err      = r_err;
        n_objs     = r_objs;
        n_phase    = r_phase;
        n_val_left = r_val_left;
        n_used     = r_used;
        n_emit     = r_emit;
        end_obj    = 1'b0;
        bundle     = '0;

        if (r_err == mbdid_pkg::ST_OK) begin
            if (r_hdr_pos < mbdid_pkg::HDR_DONE) begin
                if ((r_hdr_pos == mbdid_pkg::HDR_PROTO_HI ||
                     r_hdr_pos == mbdid_pkg::HDR_PROTO_LO) && i_rx_byte != 8'd0) begin
                    n_err = mbdid_pkg::ST_BAD_PROTO;
                end else if (r_hdr_pos == mbdid_pkg::HDR_FUNC &&
                             i_rx_byte != mbdid_pkg::FUNC_CODE) begin
                    n_err = mbdid_pkg::ST_BAD_FUNC;
                end else if (r_hdr_pos == mbdid_pkg::HDR_OBJ_COUNT) begin
                    n_objs = i_rx_byte;
                end
                n_hdr_pos = r_hdr_pos + 4'd1;
            end else if (r_objs != 8'd0) begin
                case (r_phase)
                    mbdid_pkg::PH_ID: begin
                        n_phase = mbdid_pkg::PH_LEN;
                    end
                    mbdid_pkg::PH_LEN: begin
                        n_val_left = i_rx_byte;
                        n_emit     = fits;
                        if (i_rx_byte == 8'd0) begin
                            end_obj = 1'b1;
                        end else begin
                            n_phase = mbdid_pkg::PH_VALUE;
                        end
                    end
                    default: begin
                        if (r_emit) begin
                            bundle.char_v    = 1'b1;
                            bundle.char_byte = i_rx_byte;
                            n_used           = r_used + CntW'(1);
                        end
                        n_val_left = r_val_left - 8'd1;
                        if (n_val_left == 8'd0) begin
                            end_obj = 1'b1;
                        end
                    end
                endcase
                if (end_obj) begin
                    if (n_emit) begin
                        bundle.nl_v = 1'b1;
                        n_used      = n_used + CntW'(1);
                    end
                    n_emit  = 1'b0;
                    n_objs  = r_objs - 8'd1;
                    n_phase = mbdid_pkg::PH_ID;
                end
            end
        end

        if (i_frame_last) begin
            bundle.st_v   = 1'b1;
            bundle.status = n_err;
            if (n_err == mbdid_pkg::ST_OK &&
                (n_hdr_pos < mbdid_pkg::HDR_DONE || n_objs != 8'd0)) begin
                bundle.status = mbdid_pkg::ST_TRUNC;
            end
            n_hdr_pos  = '0;
            n_err      = mbdid_pkg::ST_OK;
            n_objs     = '0;
            n_phase    = mbdid_pkg::PH_ID;
            n_val_left = '0;
            n_used     = '0;
            n_emit     = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= mbdid_pkg::CAP_RESET;
            r_hdr_pos  <= '0;
            r_err      <= mbdid_pkg::ST_OK;
            r_objs     <= '0;
            r_phase    <= mbdid_pkg::PH_ID;
            r_val_left <= '0;
            r_used     <= '0;
            r_emit     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_capacity <= i_cfg_data;
            end
            if (i_accept) begin
                r_hdr_pos  <= n_hdr_pos;
                r_err      <= n_err;
                r_objs     <= n_objs;
                r_phase    <= n_phase;
                r_val_left <= n_val_left;
                r_used     <= n_used;
                r_emit     <= n_emit;
            end
        end
    end

    assign o_push   = i_accept && (bundle.char_v || bundle.nl_v || bundle.st_v);
    assign o_bundle = bundle;

endmodule

// File: src/mbdid_out_queue.sv
// ----------------------------------------------------------------------------
// Result queue
// Two-entry bundle queue that sends each bundle as one to three result beats.
// ----------------------------------------------------------------------------
module mbdid_out_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  mbdid_pkg::t_bundle i_bundle,
    output logic               o_ready,
    mbdid_res_if.source        o_res
);

    mbdid_pkg::t_bundle r_q0, r_q1;
    logic       r_head;
    logic [1:0] r_count;
    logic [2:0] r_sent;

    mbdid_pkg::t_bundle head;
    logic [2:0] pending;
    logic [2:0] sel;
    logic       fire;
    logic       pop;
    logic       tail;

    assign head    = r_head ? r_q1 : r_q0;
    assign pending = {head.st_v, head.nl_v, head.char_v} & ~r_sent;

    always_comb begin
        if (pending[0]) begin
            sel = 3'b001;
        end else if (pending[1]) begin
            sel = 3'b010;
        end else begin
            sel = 3'b100;
        end
    end

    assign fire    = o_res.valid && o_res.ready;
    assign pop     = fire && ((pending & ~sel) == 3'b000);
    assign tail    = r_head ^ r_count[0];
    assign o_ready = (r_count != 2'd2);

    assign o_res.valid     = (r_count != 2'd0);
    assign o_res.out_byte  = sel[0] ? head.char_byte : (sel[1] ? mbdid_pkg::NEWLINE : 8'd0);
    assign o_res.is_status = sel[2];
    assign o_res.status    = sel[2] ? head.status : mbdid_pkg::ST_OK;
    assign o_res.last      = sel[2];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            if (tail) begin
                r_q1 <= i_bundle;
            end else begin
                r_q0 <= i_bundle;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= 1'b0;
            r_count <= 2'd0;
            r_sent  <= 3'b000;
        end else begin
            if (pop) begin
                r_head <= ~r_head;
                r_sent <= 3'b000;
            end else if (fire) begin
                r_sent <= r_sent | sel;
            end
            r_count <= r_count + {1'b0, i_push} - {1'b0, pop};
        end
    end

endmodule

// File: src/modbus_device_id_response_parser_core.sv
// ----------------------------------------------------------------------------
// Modbus device identification response parser
// Parses a response frame byte by byte into value characters and a status.
// ----------------------------------------------------------------------------
// Bundles are registered in the queue before their results are offered.
// Throughput: one byte per cycle while each byte yields at most one result and
// the receiver takes it; a byte with two or three results holds the output for
// each, and a two-bundle queue lets input continue while results wait.
// Reset clears all frame state and the queue and sets the capacity to 2048.
module modbus_device_id_response_parser_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    mbdid_rx_if.sink     i_rx,
    mbdid_cfg_if.sink    i_cfg,
    mbdid_res_if.source  o_res
);

    logic               accept;
    logic               push;
    logic               q_ready;
    mbdid_pkg::t_bundle bundle;

    assign i_rx.ready  = q_ready;
    assign i_cfg.ready = 1'b1;
    assign accept      = i_rx.valid && q_ready;

    mbdid_parser u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_rx_byte    (i_rx.rx_byte),
        .i_frame_last (i_rx.frame_last),
        .i_cfg_we     (i_cfg.valid),
        .i_cfg_data   (i_cfg.out_capacity),
        .o_push       (push),
        .o_bundle     (bundle)
    );

    mbdid_out_queue u_out_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_bundle (bundle),
        .o_ready  (q_ready),
        .o_res    (o_res)
    );

endmodule
